### hw/rtl/epcc_pkg.sv
package epcc_pkg;

    localparam int MAX_FRAME_BYTES_DEF = 65535;
    localparam int COUNTER_BITS_DEF    = 32;

    localparam int EVQ_DEPTH = 4;

    localparam logic [15:0] MIN_IP_FRAME = 16'd34;
    localparam logic [15:0] POS_TYPE_HI  = 16'd12;
    localparam logic [15:0] POS_TYPE_LO  = 16'd13;
    localparam logic [15:0] POS_V6_NEXT  = 16'd20;
    localparam logic [15:0] POS_V4_PROTO = 16'd23;

    localparam logic [15:0] TYPE_IPV4 = 16'h0800;
    localparam logic [15:0] TYPE_IPV6 = 16'h86DD;

    localparam logic [7:0] PROTO_ICMP   = 8'd1;
    localparam logic [7:0] PROTO_TCP    = 8'd6;
    localparam logic [7:0] PROTO_UDP    = 8'd17;
    localparam logic [7:0] PROTO_ICMPV6 = 8'd58;

    localparam logic [3:0] CLS_SHORT     = 4'd0;
    localparam logic [3:0] CLS_NON_IP    = 4'd1;
    localparam logic [3:0] CLS_V4_TCP    = 4'd2;
    localparam logic [3:0] CLS_V4_UDP    = 4'd3;
    localparam logic [3:0] CLS_V4_ICMP   = 4'd4;
    localparam logic [3:0] CLS_V4_OTHER  = 4'd5;
    localparam logic [3:0] CLS_V6_TCP    = 4'd6;
    localparam logic [3:0] CLS_V6_UDP    = 4'd7;
    localparam logic [3:0] CLS_V6_ICMPV6 = 4'd8;
    localparam logic [3:0] CLS_V6_OTHER  = 4'd9;

    localparam int NUM_CNT    = 8;
    localparam int CNT_TOTAL  = 0;
    localparam int CNT_IPV4   = 1;
    localparam int CNT_IPV6   = 2;
    localparam int CNT_TCP    = 3;
    localparam int CNT_UDP    = 4;
    localparam int CNT_ICMP   = 5;
    localparam int CNT_ICMPV6 = 6;
    localparam int CNT_OTHER  = 7;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_item;

    typedef struct packed {
        logic [3:0]  frame_class;
        logic [15:0] frame_length;
        logic [31:0] count_total;
        logic [31:0] count_ipv4;
        logic [31:0] count_ipv6;
        logic [31:0] count_tcp;
        logic [31:0] count_udp;
        logic [31:0] count_icmp;
        logic [31:0] count_icmpv6;
        logic [31:0] count_other;
        logic [47:0] byte_total;
    } t_result;

    // one classified frame, handed from parser to counters
    typedef struct packed {
        logic [3:0]  frame_class;
        logic [15:0] frame_length;
    } t_event;

endpackage

### hw/rtl/ethernet_protocol_classifier_counters.sv
// Ethernet frame classifier with running statistics. Frame bytes enter one per
// cycle unless full, through a queue-style port (push/full), starting at the
// destination MAC, with last_byte set on the final byte. A parser captures the
// EtherType and the IPv4 protocol or IPv6 next header and, on the last byte,
// hands the frame class and length to a 4-entry event queue. A counter stage
// drains that queue at one frame per cycle unless stalled, updates the eight
// frame counters and the 48-bit byte sum, and presents one result per frame at a
// registered output (empty/pop). full rises only when four frames wait behind a
// stalled result port. Frames under 34 bytes are class 0 and count as total and
// other only; frame length saturates at MAX_FRAME_BYTES and all counters wrap.
module ethernet_protocol_classifier_counters #(
    parameter int MAX_FRAME_BYTES = epcc_pkg::MAX_FRAME_BYTES_DEF,
    parameter int COUNTER_BITS    = epcc_pkg::COUNTER_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  epcc_pkg::t_item   i_item,
    output logic              empty,
    input  logic              pop,
    output epcc_pkg::t_result o_result
);

    logic             accept;
    logic             ev_push;
    epcc_pkg::t_event ev_in;
    logic             ev_valid;
    epcc_pkg::t_event ev_out;
    logic             ev_pop;

    assign accept = push && !full;

    epcc_front #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_item    (i_item),
        .o_ev_push (ev_push),
        .o_ev      (ev_in)
    );

    epcc_evq u_evq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (ev_push),
        .i_data  (ev_in),
        .o_full  (full),
        .i_pop   (ev_pop),
        .o_valid (ev_valid),
        .o_data  (ev_out)
    );

    epcc_back #(
        .COUNTER_BITS(COUNTER_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ev_valid (ev_valid),
        .i_ev       (ev_out),
        .o_ev_pop   (ev_pop),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_result   (o_result)
    );

endmodule

### hw/rtl/epcc_front.sv
module epcc_front #(
    parameter int MAX_FRAME_BYTES = epcc_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  epcc_pkg::t_item  i_item,
    output logic             o_ev_push,
    output epcc_pkg::t_event o_ev
);

    localparam logic [15:0] MAX_LEN = 16'(MAX_FRAME_BYTES);

    logic [15:0] r_pos, n_pos;
    logic [15:0] r_etype, n_etype;
    logic [7:0]  r_proto, n_proto;
    logic [15:0] len;
    logic [3:0]  cls;
    logic [7:0]  b;

    always_comb begin
        b       = i_item.data_byte;
        n_etype = r_etype;
        n_proto = r_proto;
        if (r_pos == epcc_pkg::POS_TYPE_HI) begin
            n_etype = {b, r_etype[7:0]};
        end else if (r_pos == epcc_pkg::POS_TYPE_LO) begin
            n_etype = {r_etype[15:8], b};
        end else if (r_pos == epcc_pkg::POS_V6_NEXT && r_etype == epcc_pkg::TYPE_IPV6) begin
            n_proto = b;
        end else if (r_pos == epcc_pkg::POS_V4_PROTO && r_etype == epcc_pkg::TYPE_IPV4) begin
            n_proto = b;
        end

        len = (r_pos < MAX_LEN) ? r_pos + 16'd1 : MAX_LEN;

        if (len < epcc_pkg::MIN_IP_FRAME) begin
            cls = epcc_pkg::CLS_SHORT;
        end else if (n_etype == epcc_pkg::TYPE_IPV4) begin
            case (n_proto)
                epcc_pkg::PROTO_TCP:  cls = epcc_pkg::CLS_V4_TCP;
                epcc_pkg::PROTO_UDP:  cls = epcc_pkg::CLS_V4_UDP;
                epcc_pkg::PROTO_ICMP: cls = epcc_pkg::CLS_V4_ICMP;
                default:              cls = epcc_pkg::CLS_V4_OTHER;
            endcase
        end else if (n_etype == epcc_pkg::TYPE_IPV6) begin
            case (n_proto)
                epcc_pkg::PROTO_TCP:    cls = epcc_pkg::CLS_V6_TCP;
                epcc_pkg::PROTO_UDP:    cls = epcc_pkg::CLS_V6_UDP;
                epcc_pkg::PROTO_ICMPV6: cls = epcc_pkg::CLS_V6_ICMPV6;
                default:                cls = epcc_pkg::CLS_V6_OTHER;
            endcase
        end else begin
            cls = epcc_pkg::CLS_NON_IP;
        end

        n_pos = len;
        // frame end returns the parser to its idle values
        if (i_item.last_byte) begin
            n_pos   = '0;
            n_etype = '0;
            n_proto = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_etype <= '0;
            r_proto <= '0;
        end else if (i_accept) begin
            r_pos   <= n_pos;
            r_etype <= n_etype;
            r_proto <= n_proto;
        end
    end

    assign o_ev_push       = i_accept && i_item.last_byte;
    assign o_ev.frame_class  = cls;
    assign o_ev.frame_length = len;

endmodule

### hw/rtl/epcc_evq.sv
module epcc_evq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  epcc_pkg::t_event i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output epcc_pkg::t_event o_data
);

    localparam int DEPTH  = epcc_pkg::EVQ_DEPTH;
    localparam int PTR_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    epcc_pkg::t_event r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

### hw/rtl/epcc_back.sv
module epcc_back #(
    parameter int COUNTER_BITS = epcc_pkg::COUNTER_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_ev_valid,
    input  epcc_pkg::t_event  i_ev,
    output logic              o_ev_pop,
    input  logic              i_pop,
    output logic              o_empty,
    output epcc_pkg::t_result o_result
);

    logic [COUNTER_BITS-1:0] r_cnt [epcc_pkg::NUM_CNT];
    logic [COUNTER_BITS-1:0] n_cnt [epcc_pkg::NUM_CNT];
    logic [47:0]             r_bytes, n_bytes;
    logic [epcc_pkg::NUM_CNT-1:0] bump;
    logic                    r_valid;
    epcc_pkg::t_result       r_res, n_res;
    logic                    take;

    // output slot is free or being drained this cycle
    assign take     = i_ev_valid && (!r_valid || i_pop);
    assign o_ev_pop = take;
    assign o_empty  = !r_valid;
    assign o_result = r_res;

    always_comb begin
        bump = '0;
        bump[epcc_pkg::CNT_TOTAL] = 1'b1;
        case (i_ev.frame_class)
            epcc_pkg::CLS_SHORT, epcc_pkg::CLS_NON_IP: begin
                bump[epcc_pkg::CNT_OTHER] = 1'b1;
            end
            epcc_pkg::CLS_V4_TCP: begin
                bump[epcc_pkg::CNT_IPV4] = 1'b1;
                bump[epcc_pkg::CNT_TCP]  = 1'b1;
            end
            epcc_pkg::CLS_V4_UDP: begin
                bump[epcc_pkg::CNT_IPV4] = 1'b1;
                bump[epcc_pkg::CNT_UDP]  = 1'b1;
            end
            epcc_pkg::CLS_V4_ICMP: begin
                bump[epcc_pkg::CNT_IPV4] = 1'b1;
                bump[epcc_pkg::CNT_ICMP] = 1'b1;
            end
            epcc_pkg::CLS_V4_OTHER: begin
                bump[epcc_pkg::CNT_IPV4]  = 1'b1;
                bump[epcc_pkg::CNT_OTHER] = 1'b1;
            end
            epcc_pkg::CLS_V6_TCP: begin
                bump[epcc_pkg::CNT_IPV6] = 1'b1;
                bump[epcc_pkg::CNT_TCP]  = 1'b1;
            end
            epcc_pkg::CLS_V6_UDP: begin
                bump[epcc_pkg::CNT_IPV6] = 1'b1;
                bump[epcc_pkg::CNT_UDP]  = 1'b1;
            end
            epcc_pkg::CLS_V6_ICMPV6: begin
                bump[epcc_pkg::CNT_IPV6]   = 1'b1;
                bump[epcc_pkg::CNT_ICMPV6] = 1'b1;
            end
            default: begin
                bump[epcc_pkg::CNT_IPV6]  = 1'b1;
                bump[epcc_pkg::CNT_OTHER] = 1'b1;
            end
        endcase

        for (int i = 0; i < epcc_pkg::NUM_CNT; i++) begin
            n_cnt[i] = r_cnt[i] + COUNTER_BITS'(bump[i]);
        end
        n_bytes = r_bytes + 48'(i_ev.frame_length);

        n_res.frame_class  = i_ev.frame_class;
        n_res.frame_length = i_ev.frame_length;
        n_res.count_total  = 32'(n_cnt[epcc_pkg::CNT_TOTAL]);
        n_res.count_ipv4   = 32'(n_cnt[epcc_pkg::CNT_IPV4]);
        n_res.count_ipv6   = 32'(n_cnt[epcc_pkg::CNT_IPV6]);
        n_res.count_tcp    = 32'(n_cnt[epcc_pkg::CNT_TCP]);
        n_res.count_udp    = 32'(n_cnt[epcc_pkg::CNT_UDP]);
        n_res.count_icmp   = 32'(n_cnt[epcc_pkg::CNT_ICMP]);
        n_res.count_icmpv6 = 32'(n_cnt[epcc_pkg::CNT_ICMPV6]);
        n_res.count_other  = 32'(n_cnt[epcc_pkg::CNT_OTHER]);
        n_res.byte_total   = n_bytes;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < epcc_pkg::NUM_CNT; i++) begin
                r_cnt[i] <= '0;
            end
            r_bytes <= '0;
            r_valid <= 1'b0;
        end else begin
            if (take) begin
                for (int i = 0; i < epcc_pkg::NUM_CNT; i++) begin
                    r_cnt[i] <= n_cnt[i];
                end
                r_bytes <= n_bytes;
                r_valid <= 1'b1;
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_res <= n_res;
        end
    end

endmodule
